FILE: sv/morse_letter_keyer_assert.svh
// ---------------------------------------------------------------------------
// Morse letter keyer assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ---------------------------------------------------------------------------
`ifndef MORSE_LETTER_KEYER_ASSERT_SVH
`define MORSE_LETTER_KEYER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLK_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/mlk_pkg.sv
// ---------------------------------------------------------------------------
// Morse letter keyer package
// Codes, reset values, shared types and the letter pattern table.
// ---------------------------------------------------------------------------
package mlk_pkg;

   // Width of every timing register.
   localparam int CFG_WIDTH = 16;
   // Default width of the tick counter.
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Register reset values.
   localparam logic [CFG_WIDTH-1:0] DOT_RESET  = 16'd500;
   localparam logic [CFG_WIDTH-1:0] DASH_RESET = 16'd1500;
   localparam logic [CFG_WIDTH-1:0] GAP_RESET  = 16'd500;
   localparam logic [CFG_WIDTH-1:0] WORD_RESET = 16'd1500;

   // Register indexes.
   localparam logic [1:0] REG_DOT  = 2'd0;
   localparam logic [1:0] REG_DASH = 2'd1;
   localparam logic [1:0] REG_GAP  = 2'd2;
   localparam logic [1:0] REG_WORD = 2'd3;

   // Command codes.
   localparam logic [1:0] CMD_LETTER = 2'd0;
   localparam logic [1:0] CMD_WORD   = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BUSY       = 2'd1;
   localparam logic [1:0] ST_BAD_LETTER = 2'd2;

   // ASCII range of accepted letters.
   localparam logic [7:0] LETTER_FIRST = 8'd65;
   localparam logic [7:0] LETTER_LAST  = 8'd90;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_MARK = 2'd1,
      PH_GAP  = 2'd2,
      PH_WORD = 2'd3
   } phase_type;

   // Timing registers as seen by the sequencer.
   typedef struct packed {
      logic [CFG_WIDTH-1:0] dot_ticks;
      logic [CFG_WIDTH-1:0] dash_ticks;
      logic [CFG_WIDTH-1:0] gap_ticks;
      logic [CFG_WIDTH-1:0] word_ticks;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic       key_lamp;
      logic       word_lamp;
      logic       busy_res;
      logic [1:0] status;
   } result_type;

   // Pattern per letter: high nibble is the element count, low nibble the
   // elements with bit 0 first, a set bit meaning a dash.
   function automatic logic [7:0] morse_entry(input logic [4:0] idx);
      logic [7:0] e;
      unique case (idx)
         5'd0:  e = 8'h22;
         5'd1:  e = 8'h41;
         5'd2:  e = 8'h45;
         5'd3:  e = 8'h31;
         5'd4:  e = 8'h10;
         5'd5:  e = 8'h44;
         5'd6:  e = 8'h33;
         5'd7:  e = 8'h40;
         5'd8:  e = 8'h20;
         5'd9:  e = 8'h4E;
         5'd10: e = 8'h35;
         5'd11: e = 8'h42;
         5'd12: e = 8'h23;
         5'd13: e = 8'h21;
         5'd14: e = 8'h37;
         5'd15: e = 8'h46;
         5'd16: e = 8'h4B;
         5'd17: e = 8'h32;
         5'd18: e = 8'h30;
         5'd19: e = 8'h11;
         5'd20: e = 8'h34;
         5'd21: e = 8'h48;
         5'd22: e = 8'h36;
         5'd23: e = 8'h49;
         5'd24: e = 8'h4D;
         5'd25: e = 8'h43;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

FILE: sv/morse_letter_keyer.sv
// ---------------------------------------------------------------------------
// Morse letter keyer
// Keys uppercase letters as Morse elements timed by tick beats, and shows an
// end-of-word signal, with lamp and status outputs per beat.
// ---------------------------------------------------------------------------
// Usage:
//   Request beats carry a command (letter, end of word, tick) and a letter.
//   Each request beat gives exactly one response beat with the lamps and
//   busy flag after that beat, and a status (ok, busy, bad letter).
//   The response is registered in the output register after the request is
//   taken; one request is taken in every cycle while req_stall is low.
//   Timing registers are written through the csr port while the block is
//   idle: 0 dot, 1 dash, 2 gap, 3 word, all in ticks.
//   Reset returns the sequencer to idle, empties the response side and loads
//   the default timings (500, 1500, 500, 1500).
//   When the receiver stalls, the response is held and one more request is
//   taken into a skid register; after that req_stall stays high until the
//   held response is taken.
// ---------------------------------------------------------------------------
module morse_letter_keyer #(
   parameter int COUNT_WIDTH = mlk_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [7:0]                    req_letter,
   // Response channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_key_lamp,
   output logic                          rsp_word_lamp,
   output logic                          rsp_busy_res,
   output logic [1:0]                    rsp_status,
   // Register write port.
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [mlk_pkg::CFG_WIDTH-1:0] csr_write_data
);

`include "morse_letter_keyer_assert.svh"

   mlk_pkg::cfg_type    cfg_ff;
   mlk_pkg::result_type seq_result;
   mlk_pkg::result_type out_ff, out_in;
   mlk_pkg::result_type skid_ff, skid_in;
   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic                req_take;
   logic                out_take;
   logic                park_beat;
   logic                lamps_both;
   logic                lamp_lit;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   // Timing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_ticks  <= mlk_pkg::DOT_RESET;
         cfg_ff.dash_ticks <= mlk_pkg::DASH_RESET;
         cfg_ff.gap_ticks  <= mlk_pkg::GAP_RESET;
         cfg_ff.word_ticks <= mlk_pkg::WORD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mlk_pkg::REG_DOT:  cfg_ff.dot_ticks  <= csr_write_data;
            mlk_pkg::REG_DASH: cfg_ff.dash_ticks <= csr_write_data;
            mlk_pkg::REG_GAP:  cfg_ff.gap_ticks  <= csr_write_data;
            mlk_pkg::REG_WORD: cfg_ff.word_ticks <= csr_write_data;
            default:           cfg_ff.dot_ticks  <= cfg_ff.dot_ticks;
         endcase
      end
   end

   mlk_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (req_take),
      .cmd    (req_cmd),
      .letter (req_letter),
      .cfg    (cfg_ff),
      .result (seq_result)
   );

   // Output register with one skid entry behind it.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || out_take) begin
            out_in       = seq_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = seq_result;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_lamp  = out_ff.key_lamp;
   assign rsp_word_lamp = out_ff.word_lamp;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_status    = out_ff.status;

   // Conditions watched by the checks below.
   assign park_beat  = req_take && out_valid_ff && rsp_stall;
   assign lamps_both = out_ff.key_lamp && out_ff.word_lamp;
   assign lamp_lit   = out_valid_ff && (out_ff.key_lamp || out_ff.word_lamp);

   // Checks on the response buffering and the result encoding.
   `MLK_ASSERT_SAME(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid full, output empty")
   `MLK_ASSERT_NEXT(a_stalled_take_fills_skid, park_beat, skid_valid_ff, "beat not parked")
   `MLK_ASSERT_SAME(a_lamps_exclusive, out_valid_ff, !lamps_both, "both lamps lit")
   `MLK_ASSERT_SAME(a_lamp_means_busy, lamp_lit, out_ff.busy_res, "lamp lit while not busy")

endmodule

FILE: sv/mlk_seq.sv
// ---------------------------------------------------------------------------
// Morse letter keyer sequencer
// Holds phase, pattern, element count and tick counter, and works out the
// state and result that one accepted beat leads to.
// ---------------------------------------------------------------------------
module mlk_seq #(
   parameter int COUNT_WIDTH = mlk_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [1:0]           cmd,
   input  logic [7:0]           letter,
   input  mlk_pkg::cfg_type     cfg,
   output mlk_pkg::result_type  result
);

   mlk_pkg::phase_type     phase_ff, phase_in;
   logic [3:0]             pattern_ff, pattern_in;
   logic [2:0]             elements_ff, elements_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [1:0]             status;
   logic [7:0]             entry;
   logic [7:0]             letter_offset;
   logic                   letter_bad;

   // A duration wider than the counter saturates to its largest value.
   function automatic logic [COUNT_WIDTH-1:0] load_count(
      input logic [mlk_pkg::CFG_WIDTH-1:0] v
   );
      logic [mlk_pkg::CFG_WIDTH-1:0] upper;
      upper = v >> COUNT_WIDTH;
      if (upper != '0) begin
         return '1;
      end
      return COUNT_WIDTH'(v);
   endfunction

   // Letter decode and table lookup.
   assign letter_offset = letter - mlk_pkg::LETTER_FIRST;
   assign letter_bad    = (letter < mlk_pkg::LETTER_FIRST) ||
                          (letter > mlk_pkg::LETTER_LAST);
   assign entry         = mlk_pkg::morse_entry(letter_offset[4:0]);

   // Next state for one beat.
   always_comb begin
      phase_in    = phase_ff;
      pattern_in  = pattern_ff;
      elements_in = elements_ff;
      tick_in     = tick_ff;
      status      = mlk_pkg::ST_OK;
      if (step) begin
         unique case (cmd)
            mlk_pkg::CMD_LETTER, mlk_pkg::CMD_WORD: begin
               if (phase_ff != mlk_pkg::PH_IDLE) begin
                  status = mlk_pkg::ST_BUSY;
               end else if (cmd == mlk_pkg::CMD_WORD) begin
                  phase_in = mlk_pkg::PH_WORD;
                  tick_in  = load_count(cfg.word_ticks);
               end else if (letter_bad) begin
                  status = mlk_pkg::ST_BAD_LETTER;
               end else begin
                  pattern_in  = entry[3:0];
                  elements_in = entry[6:4];
                  phase_in    = mlk_pkg::PH_MARK;
                  tick_in     = load_count(entry[0] ? cfg.dash_ticks : cfg.dot_ticks);
               end
            end
            mlk_pkg::CMD_TICK: begin
               if (phase_ff != mlk_pkg::PH_IDLE) begin
                  if (tick_ff > COUNT_WIDTH'(1)) begin
                     tick_in = tick_ff - COUNT_WIDTH'(1);
                  end else if (phase_ff == mlk_pkg::PH_MARK) begin
                     // Element done: drop it and go dark.
                     pattern_in  = pattern_ff >> 1;
                     elements_in = elements_ff - 3'd1;
                     phase_in    = mlk_pkg::PH_GAP;
                     tick_in     = load_count(cfg.gap_ticks);
                  end else if (phase_ff == mlk_pkg::PH_GAP && elements_ff != 3'd0) begin
                     phase_in = mlk_pkg::PH_MARK;
                     tick_in  = load_count(pattern_ff[0] ? cfg.dash_ticks
                                                         : cfg.dot_ticks);
                  end else begin
                     phase_in    = mlk_pkg::PH_IDLE;
                     pattern_in  = '0;
                     elements_in = '0;
                     tick_in     = '0;
                  end
               end
            end
            mlk_pkg::CMD_UNUSED: begin
               status = mlk_pkg::ST_OK;
            end
            default: begin
               status = mlk_pkg::ST_OK;
            end
         endcase
      end
   end

   // Result shows the state after the beat.
   always_comb begin
      result.key_lamp  = (phase_in == mlk_pkg::PH_MARK);
      result.word_lamp = (phase_in == mlk_pkg::PH_WORD);
      result.busy_res  = (phase_in != mlk_pkg::PH_IDLE);
      result.status    = status;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mlk_pkg::PH_IDLE;
         pattern_ff  <= '0;
         elements_ff <= '0;
         tick_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         pattern_ff  <= pattern_in;
         elements_ff <= elements_in;
         tick_ff     <= tick_in;
      end
   end

endmodule

FILE: dv/morse_letter_keyer_checker.sv
// ---------------------------------------------------------------------------
// Morse letter keyer checker
// Watches the request, response and register ports of the keyer, predicts the
// lamps, busy flag and status of every response beat from its own copy of the
// sequencer and timing registers, and counts every beat that disagrees.
// ---------------------------------------------------------------------------
module morse_letter_keyer_checker #(
   parameter int COUNT_WIDTH = mlk_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [7:0]                    req_letter,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_key_lamp,
   input  logic                          rsp_word_lamp,
   input  logic                          rsp_busy_res,
   input  logic [1:0]                    rsp_status,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [mlk_pkg::CFG_WIDTH-1:0] csr_write_data,
   output int                            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mlk_pkg::*;

   // Shadow copy of the timing registers and of the element sequencer.
   cfg_type                timing;
   phase_type              seq_phase;
   logic [3:0]             elem_bits;
   logic [2:0]             elems_left;
   logic [COUNT_WIDTH-1:0] ticks_left;

   // Lamp states still owed by the keyer, oldest first.
   result_type             lamp_queue [$];
   int                     mismatch_count;

   // Dots and dashes of each letter, first element on the left.
   function automatic string morse_code_of(input logic [7:0] ch);
      case (ch)
         "A": return ".-";
         "B": return "-...";
         "C": return "-.-.";
         "D": return "-..";
         "E": return ".";
         "F": return "..-.";
         "G": return "--.";
         "H": return "....";
         "I": return "..";
         "J": return ".---";
         "K": return "-.-";
         "L": return ".-..";
         "M": return "--";
         "N": return "-.";
         "O": return "---";
         "P": return ".--.";
         "Q": return "--.-";
         "R": return ".-.";
         "S": return "...";
         "T": return "-";
         "U": return "..-";
         "V": return "...-";
         "W": return ".--";
         "X": return "-..-";
         "Y": return "-.--";
         "Z": return "--..";
         default: return "";
      endcase
   endfunction

   // A duration too wide for the counter saturates at its largest value.
   function automatic logic [COUNT_WIDTH-1:0] clamp_ticks(input logic [CFG_WIDTH-1:0] v);
      longint unsigned ceiling;
      ceiling = (64'd1 << COUNT_WIDTH) - 64'd1;
      if (64'(v) > ceiling)
         return COUNT_WIDTH'(ceiling);
      return COUNT_WIDTH'(v);
   endfunction

   // Light the key lamp for the next element, dot or dash.
   task automatic light_element();
      seq_phase  = PH_MARK;
      ticks_left = clamp_ticks(elem_bits[0] ? timing.dash_ticks : timing.dot_ticks);
   endtask

   // Apply one request beat to the shadow sequencer and give the lamps after it.
   task automatic advance_keyer(input logic [1:0] cmd, input logic [7:0] letter,
                                output result_type lamps);
      string      code;
      int         i;
      logic [1:0] st;
      st = ST_OK;
      if (cmd == CMD_LETTER || cmd == CMD_WORD) begin
         // The busy check comes before the letter range check.
         if (seq_phase != PH_IDLE) begin
            st = ST_BUSY;
         end else if (cmd == CMD_WORD) begin
            seq_phase  = PH_WORD;
            ticks_left = clamp_ticks(timing.word_ticks);
         end else if (letter < LETTER_FIRST || letter > LETTER_LAST) begin
            st = ST_BAD_LETTER;
         end else begin
            code      = morse_code_of(letter);
            elem_bits = '0;
            for (i = 0; i < code.len(); i++)
               elem_bits[i] = (code[i] == "-");
            elems_left = 3'(code.len());
            light_element();
         end
      end else if (cmd == CMD_TICK && seq_phase != PH_IDLE) begin
         // A count of zero or one ends the current phase on this tick.
         if (ticks_left > 1) begin
            ticks_left = ticks_left - 1'b1;
         end else if (seq_phase == PH_MARK) begin
            elem_bits  = elem_bits >> 1;
            elems_left = elems_left - 3'd1;
            seq_phase  = PH_GAP;
            ticks_left = clamp_ticks(timing.gap_ticks);
         end else if (seq_phase == PH_GAP && elems_left != 0) begin
            light_element();
         end else begin
            seq_phase  = PH_IDLE;
            elem_bits  = '0;
            elems_left = '0;
            ticks_left = '0;
         end
      end
      lamps.key_lamp  = (seq_phase == PH_MARK);
      lamps.word_lamp = (seq_phase == PH_WORD);
      lamps.busy_res  = (seq_phase != PH_IDLE);
      lamps.status    = st;
   endtask

   // Compare responses, track register writes, then predict the new request.
   always @(posedge clock) begin : watch
      result_type want;
      result_type got;
      if (reset) begin
         timing.dot_ticks  = DOT_RESET;
         timing.dash_ticks = DASH_RESET;
         timing.gap_ticks  = GAP_RESET;
         timing.word_ticks = WORD_RESET;
         seq_phase         = PH_IDLE;
         elem_bits         = '0;
         elems_left        = '0;
         ticks_left        = '0;
         mismatch_count    = 0;
         lamp_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_key_lamp, rsp_word_lamp, rsp_busy_res, rsp_status};
            if (lamp_queue.size() == 0) begin
               $display("%0t: response beat with none expected:", $time,
                        " got key=%b word=%b busy=%b status=%0d",
                        got.key_lamp, got.word_lamp, got.busy_res, got.status);
               mismatch_count++;
            end else begin
               want = lamp_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: lamp mismatch:", $time,
                           " expected key=%b word=%b busy=%b status=%0d,",
                           want.key_lamp, want.word_lamp, want.busy_res, want.status,
                           " got key=%b word=%b busy=%b status=%0d",
                           got.key_lamp, got.word_lamp, got.busy_res, got.status);
                  mismatch_count++;
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_DOT:  timing.dot_ticks  = csr_write_data;
               REG_DASH: timing.dash_ticks = csr_write_data;
               REG_GAP:  timing.gap_ticks  = csr_write_data;
               REG_WORD: timing.word_ticks = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_keyer(req_cmd, req_letter, want);
            lamp_queue.push_back(want);
         end
      end
      // Anything still owed counts against the run when the top reads this.
      fail_count <= mismatch_count + lamp_queue.size();
   end

endmodule

FILE: dv/tb_morse_letter_keyer.sv
// ---------------------------------------------------------------------------
// Morse letter keyer testbench
// Drives letters, end-of-word marks, ticks and unused commands into the keyer
// under several timing settings and three idling patterns, holds the response
// side off long enough to fill the keyer, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_morse_letter_keyer;
   timeunit 1ns;
   timeprecision 1ps;
   import mlk_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_BEATS = 185;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_cmd;
   logic [7:0]           req_letter;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_key_lamp;
   logic                 rsp_word_lamp;
   logic                 rsp_busy_res;
   logic [1:0]           rsp_status;
   logic                 csr_write_enable;
   logic [1:0]           csr_index;
   logic [CFG_WIDTH-1:0] csr_write_data;
   int                   fail_count;

   // Idling percentages, hold-off bookkeeping and beat counts.
   int                   send_idle_pct = 37;
   int                   rsp_idle_pct = 75;
   int                   hold_requests = 0;
   int                   hold_served = 0;
   int                   sent_beats = 0;
   int                   rsp_beats;
   logic                 keyer_busy;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   morse_letter_keyer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_letter       (req_letter),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_lamp     (rsp_key_lamp),
      .rsp_word_lamp    (rsp_word_lamp),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   morse_letter_keyer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_letter       (req_letter),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_lamp     (rsp_key_lamp),
      .rsp_word_lamp    (rsp_word_lamp),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count)
   );

   // Receiver: random stall per cycle, or a long hold-off when one is asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_served++;
         end
         rsp_stall = ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Count response beats and remember whether the keyer was still busy.
   always @(posedge clock) begin
      if (reset) begin
         rsp_beats  <= 0;
         keyer_busy <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_beats  <= rsp_beats + 1;
         keyer_busy <= rsp_busy_res;
      end
   end

   // Offer one request beat after a random idle stretch; returns at a falling edge.
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] letter);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid  = 1'b1;
      req_cmd    = cmd;
      req_letter = letter;
      do @(posedge clock); while (req_stall);
      sent_beats++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every request beat has its response.
   task automatic wait_quiet();
      req_valid = 1'b0;
      while (rsp_beats != sent_beats)
         @(negedge clock);
   endtask

   // Tick the keyer until it reports idle, so a new setting starts clean.
   task automatic settle_keyer();
      int k;
      wait_quiet();
      while (keyer_busy) begin
         for (k = 0; k < 16; k++)
            send_beat(CMD_TICK, 8'($urandom_range(255)));
         wait_quiet();
      end
   endtask

   // Load all four timing registers while nothing is in flight.
   task automatic set_timing(input logic [CFG_WIDTH-1:0] dot, input logic [CFG_WIDTH-1:0] dash,
                             input logic [CFG_WIDTH-1:0] gap, input logic [CFG_WIDTH-1:0] word);
      wait_quiet();
      csr_write_enable = 1'b1;
      csr_index        = REG_DOT;
      csr_write_data   = dot;
      @(negedge clock);
      csr_index        = REG_DASH;
      csr_write_data   = dash;
      @(negedge clock);
      csr_index        = REG_GAP;
      csr_write_data   = gap;
      @(negedge clock);
      csr_index        = REG_WORD;
      csr_write_data   = word;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Mostly ticks and good letters so that whole letters get keyed, with
   // word marks, wild letter codes and the unused command mixed in.
   task automatic run_random(input int count);
      int n;
      int pick;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_beat(CMD_TICK, 8'($urandom_range(255)));
         else if (pick < 75)
            send_beat(CMD_LETTER, LETTER_FIRST + 8'($urandom_range(25)));
         else if (pick < 83)
            send_beat(CMD_LETTER, 8'($urandom_range(255)));
         else if (pick < 93)
            send_beat(CMD_WORD, 8'($urandom_range(255)));
         else
            send_beat(CMD_UNUSED, 8'($urandom_range(255)));
      end
      settle_keyer();
   endtask

   // Stimulus and verdict.
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_TICK;
      req_letter       = 8'h00;
      csr_write_enable = 1'b0;
      csr_index        = REG_DOT;
      csr_write_data   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Commands that leave an idle keyer alone.
      send_beat(CMD_UNUSED, 8'hFF);
      send_beat(CMD_TICK, 8'h00);
      // Letter codes just outside A to Z and at the field extremes.
      send_beat(CMD_LETTER, 8'h00);
      send_beat(CMD_LETTER, LETTER_FIRST - 8'd1);
      send_beat(CMD_LETTER, LETTER_LAST + 8'd1);
      send_beat(CMD_LETTER, "a");
      send_beat(CMD_LETTER, 8'hFF);

      // Short timing, then end of word and requests while it is shown.
      set_timing(16'd1, 16'd2, 16'd1, 16'd1);
      send_beat(CMD_WORD, 8'h00);
      send_beat(CMD_LETTER, "A");
      // Busy is reported ahead of a bad letter.
      send_beat(CMD_LETTER, 8'hFF);
      send_beat(CMD_WORD, 8'h55);
      send_beat(CMD_UNUSED, 8'hAA);
      send_beat(CMD_TICK, 8'h00);
      settle_keyer();

      // The first and last letters and the one-element ones.
      send_beat(CMD_LETTER, LETTER_FIRST);
      settle_keyer();
      send_beat(CMD_LETTER, LETTER_LAST);
      settle_keyer();
      send_beat(CMD_LETTER, "E");
      settle_keyer();
      send_beat(CMD_LETTER, "T");
      send_beat(CMD_LETTER, "Q");
      settle_keyer();
      run_random(RANDOM_BEATS);

      // Zero durations behave as a single tick.
      set_timing(16'd0, 16'd0, 16'd0, 16'd0);
      run_random(RANDOM_BEATS);

      // Sender idles more than the receiver now.
      send_idle_pct = 75;
      rsp_idle_pct  = 37;
      set_timing(16'($urandom_range(5, 1)), 16'($urandom_range(5, 1)),
                 16'($urandom_range(5, 1)), 16'($urandom_range(5, 1)));
      run_random(RANDOM_BEATS);
      // Dash shorter than dot.
      set_timing(16'd3, 16'd1, 16'd2, 16'd4);
      run_random(RANDOM_BEATS);

      // No idling on either side; open with a long hold-off so the keyer fills.
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      set_timing(16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)),
                 16'($urandom_range(8, 1)), 16'($urandom_range(8, 1)));
      hold_requests++;
      run_random(RANDOM_BEATS);

      // Longest durations: a short letter, a rejected end of word and one
      // tick; the run ends while the letter is still being keyed.
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(CMD_LETTER, "E");
      send_beat(CMD_WORD, 8'h00);
      send_beat(CMD_TICK, 8'hFF);

      wait_quiet();
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("tb_morse_letter_keyer passed");
      else
         $display("tb_morse_letter_keyer failed");
      $finish;
   end

   // Watchdog for a keyer that hangs.
   initial begin
      #10ms;
      $display("tb_morse_letter_keyer failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/mlk_pkg.sv
sv/mlk_seq.sv
sv/morse_letter_keyer.sv
dv/morse_letter_keyer_checker.sv
dv/tb_morse_letter_keyer.sv
